[src/assert_macros.svh]
// Assertion macros used by the filter core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert that a condition implies a consequence in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");
`endif

[src/fmpf_pkg.sv]
// Package with constants, request codes and state types for the packet filter.
package fmpf_pkg;
    localparam int unsigned RULES_DEF = 32;

    typedef enum logic [2:0] {
        REQ_CHECK = 3'd0,
        REQ_WRITE = 3'd1,
        REQ_STATS = 3'd2,
        REQ_CLEAR = 3'd3,
        REQ_TOTAL = 3'd4
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_CLEAR,
        ST_DONE
    } t_state;

    localparam logic [2:0] W_SRC_ADDR = 3'd0;
    localparam logic [2:0] W_SRC_MASK = 3'd1;
    localparam logic [2:0] W_DST_ADDR = 3'd2;
    localparam logic [2:0] W_DST_MASK = 3'd3;
    localparam logic [2:0] W_SRC_PORT = 3'd4;
    localparam logic [2:0] W_DST_PORT = 3'd5;
    localparam logic [2:0] W_CTRL     = 3'd6;

    localparam logic [1:0] DIR_IN  = 2'd1;
    localparam logic [1:0] DIR_OUT = 2'd2;

    localparam logic [31:0] ADDR_ALL_ONES = 32'hFFFF_FFFF;

    function automatic logic addr_ok(input logic [31:0] a, input logic [31:0] ra,
                                     input logic [31:0] m);
        logic [31:0] mm;
        mm = (m == '0) ? ADDR_ALL_ONES : m;
        return (ra == '0) || ((a & mm) == (ra & mm));
    endfunction

    function automatic logic port_ok(input logic [15:0] p, input logic [31:0] w);
        logic [15:0] lo;
        logic [15:0] hi;
        lo = w[31:16];
        hi = (w[15:0] == '0) ? w[31:16] : w[15:0];
        return ((w[31:16] == '0) && (w[15:0] == '0)) || ((p >= lo) && (p <= hi));
    endfunction
endpackage

[src/fmpf_rule_mem.sv]
// Rule word memory: one wide row of address and port words per slot.
module fmpf_rule_mem import fmpf_pkg::*; #(
    parameter int unsigned RULES = RULES_DEF,
    localparam int unsigned SW = (RULES > 1) ? $clog2(RULES) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [SW-1:0] i_waddr,
    input  logic [2:0]    i_wsel,
    input  logic [31:0]   i_wdata,
    input  logic [SW-1:0] i_raddr,
    output logic [191:0]  o_rdata
);
    logic [31:0] r_mem0 [RULES];
    logic [31:0] r_mem1 [RULES];
    logic [31:0] r_mem2 [RULES];
    logic [31:0] r_mem3 [RULES];
    logic [31:0] r_mem4 [RULES];
    logic [31:0] r_mem5 [RULES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            unique case (i_wsel)
                W_SRC_ADDR: r_mem0[i_waddr] <= i_wdata;
                W_SRC_MASK: r_mem1[i_waddr] <= i_wdata;
                W_DST_ADDR: r_mem2[i_waddr] <= i_wdata;
                W_DST_MASK: r_mem3[i_waddr] <= i_wdata;
                W_SRC_PORT: r_mem4[i_waddr] <= i_wdata;
                W_DST_PORT: r_mem5[i_waddr] <= i_wdata;
                default: ;
            endcase
        end
        o_rdata <= {r_mem5[i_raddr], r_mem4[i_raddr], r_mem3[i_raddr],
                    r_mem2[i_raddr], r_mem1[i_raddr], r_mem0[i_raddr]};
    end
endmodule

[src/first_match_packet_filter_core.sv]
// First-match packet filter: top level with control sequencer and statistics.
// A check walks the rule slots one per cycle from slot 0 when the filter is
// enabled and stops at the first match or after the last slot; the walk is set
// by the single read port of the rule memory. Writes, statistic reads and
// total reads pass through ST_READ and ST_DONE; clear-all walks every slot in
// ST_CLEAR. busy is high while an item is in work; the result is on the
// outputs for one cycle with o_valid and cannot be stalled.
`include "assert_macros.svh"
module first_match_packet_filter_core import fmpf_pkg::*; #(
    parameter int unsigned RULES = RULES_DEF,
    localparam int unsigned SW = (RULES > 1) ? $clog2(RULES) : 1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [0:0]  i_cfg_data,
    input  logic [2:0]  i_req_type,
    input  logic        i_pkt_outgoing,
    input  logic [31:0] i_src_addr,
    input  logic [15:0] i_src_port_num,
    input  logic [31:0] i_dst_addr,
    input  logic [15:0] i_dst_port_num,
    input  logic [1:0]  i_pkt_proto,
    input  logic [4:0]  i_slot_sel,
    input  logic [2:0]  i_word_sel,
    input  logic [31:0] i_word_value,
    input  logic [31:0] i_now_tick,
    output logic        o_valid,
    output logic        o_verdict_block,
    output logic        o_rule_hit,
    output logic [4:0]  o_hit_slot,
    output logic        o_log_request,
    output logic [63:0] o_read_value
);
    t_state r_state, n_state;
    logic r_fen, r_din, r_dout, r_dlog;
    logic [2:0]  r_req;
    logic        r_out;
    logic [31:0] r_sa, r_da, r_wval, r_tick;
    logic [15:0] r_sp, r_dp;
    logic [1:0]  r_proto;
    logic [4:0]  r_slot;
    logic [2:0]  r_wsel;
    logic [SW:0] r_idx, n_idx;
    logic [6:0]  r_ctrl [RULES];
    logic [63:0] r_stat [RULES];
    logic [63:0] r_stat_q;
    logic [31:0] r_tot [4];
    logic        r_found, n_found;
    logic [SW-1:0] r_hidx, n_hidx;
    logic [191:0] rule_q;
    logic [SW-1:0] raddr;
    logic [SW-1:0] slot_idx;
    logic        slot_ok;
    logic        accept;
    logic        match;
    logic [6:0]  c;
    logic [SW-1:0] cur;

    assign accept = start && (r_state == ST_IDLE);
    assign busy = (r_state != ST_IDLE);
    assign slot_idx = SW'(r_slot);
    assign slot_ok = ({4'd0, r_slot} < 9'(RULES));
    assign cur = r_idx[SW-1:0];
    assign raddr = (r_state == ST_IDLE) ? '0 : n_idx[SW-1:0];

    fmpf_rule_mem #(.RULES(RULES)) u_mem (
        .i_clk  (i_clk),
        .i_we   (r_state == ST_READ && r_req == REQ_WRITE && slot_ok),
        .i_waddr(slot_idx),
        .i_wsel (r_wsel),
        .i_wdata(r_wval),
        .i_raddr(raddr),
        .o_rdata(rule_q)
    );

    always_comb begin
        c = r_ctrl[cur];
        match = c[0]
            && !(r_out ? (c[3:2] == DIR_IN) : (c[3:2] == DIR_OUT))
            && (c[5:4] == 2'd0 || c[5:4] == r_proto)
            && (r_out || (addr_ok(r_sa, rule_q[31:0], rule_q[63:32])
                          && port_ok(r_sp, rule_q[159:128])))
            && addr_ok(r_da, rule_q[95:64], rule_q[127:96])
            && port_ok(r_dp, rule_q[191:160]);
    end

    always_comb begin
        n_state = r_state;
        n_idx = r_idx;
        n_found = r_found;
        n_hidx = r_hidx;
        unique case (r_state)
            ST_IDLE: begin
                n_idx = '0;
                n_found = 1'b0;
                if (start) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                priority if (r_req == REQ_CHECK && r_fen) begin
                    n_state = ST_EVAL;
                end else if (r_req == REQ_CLEAR) begin
                    n_state = ST_CLEAR;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_EVAL: begin
                n_idx = r_idx + 1'b1;
                if (match) begin
                    n_found = 1'b1;
                    n_hidx = cur;
                    n_state = ST_DONE;
                end else if (r_idx == (SW+1)'(RULES - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_CLEAR: begin
                n_idx = r_idx + 1'b1;
                if (r_idx == (SW+1)'(RULES - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fen <= 1'b0;
            r_din <= 1'b1;
            r_dout <= 1'b0;
            r_dlog <= 1'b1;
            r_idx <= '0;
            r_found <= 1'b0;
            r_hidx <= '0;
            o_valid <= 1'b0;
            for (int i = 0; i < RULES; i++) begin
                r_ctrl[i] <= '0;
                r_stat[i] <= '0;
            end
            for (int i = 0; i < 4; i++) begin
                r_tot[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_idx <= n_idx;
            r_found <= n_found;
            r_hidx <= n_hidx;
            o_valid <= (r_state == ST_DONE);
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    2'd0: r_fen <= i_cfg_data[0];
                    2'd1: r_din <= i_cfg_data[0];
                    2'd2: r_dout <= i_cfg_data[0];
                    2'd3: r_dlog <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_state == ST_READ && r_req == REQ_WRITE && slot_ok
                && r_wsel == W_CTRL) begin
                if (r_wval[0] && !r_ctrl[slot_idx][0]) begin
                    r_stat[slot_idx] <= '0;
                end
                r_ctrl[slot_idx] <= r_wval[6:0];
            end
            if (r_state == ST_READ && r_req == REQ_CHECK && r_fen) begin
                r_tot[{1'b0, r_out}] <= r_tot[{1'b0, r_out}] + 1'b1;
            end
            if (r_state == ST_CLEAR) begin
                r_ctrl[cur][0] <= 1'b0;
            end
            if (r_state == ST_EVAL && match) begin
                r_stat[cur] <= {r_stat[cur][63:32] + 1'b1, r_tick};
            end
            if (r_state == ST_DONE && r_req == REQ_CHECK && r_fen && !r_found) begin
                if (r_out ? r_dout : r_din) begin
                    r_tot[2] <= r_tot[2] + 1'b1;
                end else begin
                    r_tot[3] <= r_tot[3] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req_type;
            r_out <= i_pkt_outgoing;
            r_sa <= i_src_addr;
            r_sp <= i_src_port_num;
            r_da <= i_dst_addr;
            r_dp <= i_dst_port_num;
            r_proto <= i_pkt_proto;
            r_slot <= i_slot_sel;
            r_wsel <= i_word_sel;
            r_wval <= i_word_value;
            r_tick <= i_now_tick;
        end
        if (r_state == ST_READ) begin
            r_stat_q <= r_stat[slot_idx];
        end
        if (r_state == ST_DONE) begin
            o_verdict_block <= 1'b0;
            o_rule_hit <= 1'b0;
            o_hit_slot <= '0;
            o_log_request <= 1'b0;
            o_read_value <= '0;
            priority if (r_req == REQ_CHECK) begin
                if (r_fen) begin
                    if (r_found) begin
                        o_verdict_block <= r_ctrl[r_hidx][1];
                        o_rule_hit <= 1'b1;
                        o_hit_slot <= 5'(r_hidx);
                        o_log_request <= r_ctrl[r_hidx][6];
                    end else begin
                        o_verdict_block <= r_out ? r_dout : r_din;
                        o_log_request <= (r_out ? r_dout : r_din) && r_dlog;
                    end
                end
            end else if (r_req == REQ_STATS) begin
                if (slot_ok) begin
                    o_read_value <= r_stat_q;
                end
            end else if (r_req == REQ_TOTAL) begin
                if (r_wsel < 3'd4) begin
                    o_read_value <= {32'd0, r_tot[r_wsel[1:0]]};
                end
            end
        end
    end

    `ASSERT_NEXT(a_done_valid, i_clk, i_rst_n, r_state == ST_DONE, o_valid)
    `ASSERT_IMPL(a_valid_idle, i_clk, i_rst_n, o_valid, r_state == ST_IDLE)
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, busy)
endmodule

[dv/tb_first_match_packet_filter_core.sv]
// Self-checking testbench for the first-match packet filter core.
module tb_first_match_packet_filter_core import fmpf_pkg::*;;

    localparam logic [1:0] CFG_ENABLE  = 2'd0;
    localparam logic [1:0] CFG_DEF_IN  = 2'd1;
    localparam logic [1:0] CFG_DEF_OUT = 2'd2;
    localparam logic [1:0] CFG_LOG_DEF = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [2:0]  req;
        logic        outgoing;
        logic [31:0] src_addr;
        logic [15:0] sport;
        logic [31:0] dst_addr;
        logic [15:0] dport;
        logic [1:0]  proto;
        logic [4:0]  slot;
        logic [2:0]  wsel;
        logic [31:0] wval;
        logic [31:0] tick;
    } t_req_word;

    typedef struct packed {
        logic        block;
        logic        hit;
        logic [4:0]  slot;
        logic        log;
        logic [63:0] rd;
    } t_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [0:0] i_cfg_data = '0;
    t_req_word cur = '0;
    logic o_valid, o_verdict_block, o_rule_hit, o_log_request;
    logic [4:0] o_hit_slot;
    logic [63:0] o_read_value;

    first_match_packet_filter_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_req_type(cur.req), .i_pkt_outgoing(cur.outgoing),
        .i_src_addr(cur.src_addr), .i_src_port_num(cur.sport),
        .i_dst_addr(cur.dst_addr), .i_dst_port_num(cur.dport),
        .i_pkt_proto(cur.proto), .i_slot_sel(cur.slot), .i_word_sel(cur.wsel),
        .i_word_value(cur.wval), .i_now_tick(cur.tick),
        .o_valid(o_valid), .o_verdict_block(o_verdict_block), .o_rule_hit(o_rule_hit),
        .o_hit_slot(o_hit_slot), .o_log_request(o_log_request), .o_read_value(o_read_value)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // predictor state
    logic        m_enable, m_def_in, m_def_out, m_log_def;
    logic [31:0] m_addr [128];
    logic [31:0] m_port [64];
    logic [6:0]  m_ctrl [32];
    logic [31:0] m_hits [32];
    logic [31:0] m_tick [32];
    logic [31:0] m_total [4];

    // generator view of the rule table
    logic [31:0] g_addr [32][4];
    logic [31:0] g_port [32][2];
    logic [6:0]  g_ctrl [32];
    logic [5:0]  g_written [32];

    t_req_word pend_q[$];
    t_verdict  verdict_q[$];
    int errors = 0;
    int n_checks = 0;
    int n_hits = 0;
    int n_results = 0;
    int gap = 0;
    bit no_idle = 0;
    int stall = 0;

    function automatic bit addr_match(logic [31:0] a, logic [31:0] ra, logic [31:0] m);
        logic [31:0] mm;
        mm = (m == 32'd0) ? ADDR_ALL_ONES : m;
        return (ra == 32'd0) || ((a & mm) == (ra & mm));
    endfunction

    function automatic bit port_match(logic [15:0] p, logic [31:0] w);
        logic [15:0] lo;
        logic [15:0] hi;
        lo = w[31:16];
        hi = (w[15:0] == 16'd0) ? lo : w[15:0];
        if (w == 32'd0) return 1'b1;
        return (p >= lo) && (p <= hi);
    endfunction

    function automatic t_verdict filter_predict(t_req_word r);
        t_verdict v;
        bit found;
        logic [6:0] c;
        v = '0;
        found = 0;
        case (r.req)
            REQ_CHECK: begin
                if (m_enable) begin
                    m_total[r.outgoing ? 1 : 0]++;
                    for (int i = 0; i < 32; i++) begin
                        c = m_ctrl[i];
                        if (found || !c[0]) continue;
                        if (r.outgoing ? (c[3:2] == DIR_IN) : (c[3:2] == DIR_OUT)) continue;
                        if (c[5:4] != 2'd0 && c[5:4] != r.proto) continue;
                        if (!r.outgoing) begin
                            if (!addr_match(r.src_addr, m_addr[i*4], m_addr[i*4+1])) continue;
                            if (!port_match(r.sport, m_port[i*2])) continue;
                        end
                        if (!addr_match(r.dst_addr, m_addr[i*4+2], m_addr[i*4+3])) continue;
                        if (!port_match(r.dport, m_port[i*2+1])) continue;
                        found = 1;
                        m_hits[i]++;
                        m_tick[i] = r.tick;
                        v.block = c[1];
                        v.hit = 1'b1;
                        v.slot = i[4:0];
                        v.log = c[6];
                    end
                    if (!found) begin
                        v.block = r.outgoing ? m_def_out : m_def_in;
                        if (v.block) begin
                            m_total[2]++;
                            v.log = m_log_def;
                        end else begin
                            m_total[3]++;
                        end
                    end
                end
            end
            REQ_WRITE: begin
                if (r.wsel < 3'd4) begin
                    m_addr[r.slot*4+r.wsel] = r.wval;
                end else if (r.wsel < 3'd6) begin
                    m_port[r.slot*2+(r.wsel-4)] = r.wval;
                end else if (r.wsel == W_CTRL) begin
                    if (r.wval[0] && !m_ctrl[r.slot][0]) begin
                        m_hits[r.slot] = 32'd0;
                        m_tick[r.slot] = 32'd0;
                    end
                    m_ctrl[r.slot] = r.wval[6:0];
                end
            end
            REQ_STATS: v.rd = {m_hits[r.slot], m_tick[r.slot]};
            REQ_CLEAR: for (int i = 0; i < 32; i++) m_ctrl[i][0] = 1'b0;
            REQ_TOTAL: if (r.wsel < 3'd4) v.rd = {32'd0, m_total[r.wsel[1:0]]};
            default: ;
        endcase
        return v;
    endfunction

    function automatic t_req_word rand_word(logic [2:0] req);
        t_req_word r;
        r = $bits(t_req_word)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        r.req = req;
        return r;
    endfunction

    task automatic push_req(t_req_word r);
        if (r.req == REQ_WRITE) begin
            if (r.wsel < 3'd4) g_addr[r.slot][r.wsel] = r.wval;
            else if (r.wsel < 3'd6) g_port[r.slot][r.wsel-4] = r.wval;
            else if (r.wsel == W_CTRL) g_ctrl[r.slot] = r.wval[6:0];
            if (r.wsel < 3'd6) g_written[r.slot][r.wsel] = 1'b1;
        end else if (r.req == REQ_CLEAR) begin
            for (int i = 0; i < 32; i++) g_ctrl[i][0] = 1'b0;
        end
        pend_q.push_back(r);
    endtask

    task automatic push_write(logic [4:0] slot, logic [2:0] wsel, logic [31:0] val);
        t_req_word r;
        r = rand_word(REQ_WRITE);
        r.slot = slot;
        r.wsel = wsel;
        r.wval = val;
        push_req(r);
    endtask

    function automatic logic [31:0] rand_addr();
        return ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom;
    endfunction

    function automatic logic [31:0] rand_mask();
        case ($urandom_range(0, 3))
            0: return 32'd0;
            1: return 32'hFFFF_FF00;
            2: return 32'hFFFF_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_ports();
        logic [15:0] lo;
        lo = 16'($urandom);
        case ($urandom_range(0, 3))
            0: return 32'd0;
            1: return {lo, 16'd0};
            2: return {lo, 16'hFFFF};
            default: return {lo, lo + 16'($urandom_range(0, 40))};
        endcase
    endfunction

    // a control word with enable set only after all six words of the slot are written
    task automatic push_rule(logic [4:0] slot, logic [6:0] ctrl);
        push_write(slot, W_SRC_ADDR, rand_addr());
        push_write(slot, W_SRC_MASK, rand_mask());
        push_write(slot, W_DST_ADDR, rand_addr());
        push_write(slot, W_DST_MASK, rand_mask());
        push_write(slot, W_SRC_PORT, rand_ports());
        push_write(slot, W_DST_PORT, rand_ports());
        push_write(slot, W_CTRL, {25'd0, ctrl});
    endtask

    function automatic t_req_word aimed_check(logic [4:0] s);
        t_req_word r;
        logic [6:0] c;
        r = rand_word(REQ_CHECK);
        c = g_ctrl[s];
        if (c[3:2] == DIR_IN) r.outgoing = 1'b0;
        else if (c[3:2] == DIR_OUT) r.outgoing = 1'b1;
        if (c[5:4] != 2'd0) r.proto = c[5:4];
        if ($urandom_range(0, 9) != 0) begin
            r.src_addr = (g_addr[s][0] & g_addr[s][1]) | (r.src_addr & ~g_addr[s][1]);
            if (g_addr[s][1] == 32'd0) r.src_addr = g_addr[s][0];
            r.dst_addr = (g_addr[s][2] & g_addr[s][3]) | (r.dst_addr & ~g_addr[s][3]);
            if (g_addr[s][3] == 32'd0) r.dst_addr = g_addr[s][2];
            if (g_port[s][0] != 32'd0) r.sport = g_port[s][0][31:16];
            if (g_port[s][1] != 32'd0) r.dport = g_port[s][1][31:16];
        end
        return r;
    endfunction

    task automatic push_random(int count);
        t_req_word r;
        logic [4:0] s;
        int sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            s = 5'($urandom);
            if (sel < 30) begin
                push_req(aimed_check(s));
            end else if (sel < 45) begin
                push_req(rand_word(REQ_CHECK));
            end else if (sel < 53) begin
                push_rule(s, 7'($urandom) | 7'd1);
                n += 6;
            end else if (sel < 63) begin
                r = rand_word(REQ_WRITE);
                r.slot = s;
                if (r.wsel == W_CTRL && r.wval[0] && g_written[s] != 6'h3F)
                    r.wval[0] = g_ctrl[s][0];
                push_req(r);
            end else if (sel < 78) begin
                r = rand_word(REQ_STATS);
                push_req(r);
            end else if (sel < 80) begin
                push_req(rand_word(REQ_CLEAR));
            end else if (sel < 92) begin
                push_req(rand_word(REQ_TOTAL));
            end else begin
                push_req(rand_word(3'($urandom_range(5, 7))));
            end
        end
    endtask

    task automatic cfg_write(logic [1:0] idx, logic val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ENABLE:  m_enable = val;
            CFG_DEF_IN:  m_def_in = val;
            CFG_DEF_OUT: m_def_out = val;
            default:     m_log_def = val;
        endcase
    endtask

    task automatic set_config(logic en, logic din, logic dout, logic lg);
        cfg_write(CFG_ENABLE, en);
        cfg_write(CFG_DEF_IN, din);
        cfg_write(CFG_DEF_OUT, dout);
        cfg_write(CFG_LOG_DEF, lg);
    endtask

    task automatic drain();
        wait (pend_q.size() == 0 && !start && verdict_q.size() == 0);
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // driver: hold the word until accepted, then idle for a drawn gap
    always @(posedge i_clk) begin
        int g;
        if (!i_rst_n) begin
            start <= 1'b0;
            gap <= 0;
        end else if (start && !busy) begin
            verdict_q.push_back(filter_predict(cur));
            if (cur.req == REQ_CHECK) n_checks++;
            g = no_idle ? 0 : $urandom_range(0, 19);
            if (g == 0 && pend_q.size() > 0) begin
                cur <= pend_q.pop_front();
            end else begin
                start <= 1'b0;
                gap <= (g > 0) ? g - 1 : 0;
            end
        end else if (!start) begin
            if (gap > 0) begin
                gap <= gap - 1;
            end else if (pend_q.size() > 0) begin
                cur <= pend_q.pop_front();
                start <= 1'b1;
            end
        end
    end

    // monitor: compare each result against the oldest prediction
    always @(posedge i_clk) begin
        t_verdict e;
        t_verdict a;
        if (i_rst_n && o_valid) begin
            a = {o_verdict_block, o_rule_hit, o_hit_slot, o_log_request, o_read_value};
            n_results++;
            if (verdict_q.size() == 0) begin
                errors++;
                $display("%0t unexpected result exp none got %h", $time, a);
            end else begin
                e = verdict_q.pop_front();
                if (e.hit) n_hits++;
                if (e.block !== a.block)
                    $display("%0t verdict_block exp %0d got %0d", $time, e.block, a.block);
                if (e.hit !== a.hit)
                    $display("%0t rule_hit exp %0d got %0d", $time, e.hit, a.hit);
                if (e.slot !== a.slot)
                    $display("%0t hit_slot exp %0d got %0d", $time, e.slot, a.slot);
                if (e.log !== a.log)
                    $display("%0t log_request exp %0d got %0d", $time, e.log, a.log);
                if (e.rd !== a.rd)
                    $display("%0t read_value exp %h got %h", $time, e.rd, a.rd);
                if (e !== a) errors++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && (start || busy || verdict_q.size() > 0)
                && !(start && !busy) && !o_valid) begin
            stall <= stall + 1;
            if (stall >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end else begin
            stall <= 0;
        end
    end

    initial begin
        t_req_word r;
        m_enable = 1'b0; m_def_in = 1'b1; m_def_out = 1'b0; m_log_def = 1'b1;
        for (int i = 0; i < 32; i++) begin
            m_ctrl[i] = '0; m_hits[i] = '0; m_tick[i] = '0;
            g_ctrl[i] = '0; g_written[i] = '0;
        end
        for (int i = 0; i < 4; i++) m_total[i] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: disabled filter, defaults, one rule, reads, odd selects
        push_req(rand_word(REQ_CHECK));
        drain();
        cfg_write(CFG_ENABLE, 1'b1);
        r = rand_word(REQ_CHECK); r.outgoing = 1'b0; push_req(r);
        r = rand_word(REQ_CHECK); r.outgoing = 1'b1; push_req(r);
        push_write(5'd0, W_SRC_ADDR, 32'd0);
        push_write(5'd0, W_SRC_MASK, 32'd0);
        push_write(5'd0, W_DST_ADDR, 32'hFFFF_FFFF);
        push_write(5'd0, W_DST_MASK, 32'd0);
        push_write(5'd0, W_SRC_PORT, 32'd0);
        push_write(5'd0, W_DST_PORT, {16'hFFFF, 16'd0});
        push_write(5'd31, W_CTRL, 32'hFFFF_FF80);
        push_write(5'd0, W_CTRL, 32'h0000_0043);
        r = rand_word(REQ_CHECK); r.dst_addr = '1; r.dport = '1; r.tick = '1;
        push_req(r);
        r.outgoing = ~r.outgoing; r.tick = '0; push_req(r);
        r = rand_word(REQ_STATS); r.slot = 5'd0; push_req(r);
        r = rand_word(REQ_STATS); r.slot = 5'd31; push_req(r);
        for (int w = 0; w < 5; w++) begin
            r = rand_word(REQ_TOTAL); r.wsel = w[2:0]; push_req(r);
        end
        push_write(5'd3, 3'd7, '1);
        push_req(rand_word(3'd5));
        push_req(rand_word(REQ_CLEAR));
        r = rand_word(REQ_CHECK); r.dst_addr = '1; r.dport = '1; push_req(r);
        drain();

        set_config(1'b1, 1'b1, 1'b0, 1'b1); push_random(120); drain();
        set_config(1'b1, 1'b0, 1'b1, 1'b0); no_idle = 1; push_random(120); drain();
        set_config(1'b0, 1'b1, 1'b1, 1'b1); no_idle = 0; push_random(100); drain();
        set_config(1'b1, 1'b1, 1'b1, 1'b1); push_random(120); drain();
        set_config(1'b1, 1'b0, 1'b0, 1'b0); push_random(120); drain();
        set_config(1'b1, 1'($urandom), 1'($urandom), 1'($urandom));
        no_idle = 1; push_random(60); drain();
        repeat (50) @(posedge i_clk);

        $display("Covered %0d results, %0d packet checks, %0d rule hits, %0d mismatches.",
                 n_results, n_checks, n_hits, errors);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
